// ===== hw/rtl/mrp_pkg.sv =====
// shared types, constants and the crc-16 byte update for the modbus reply parser
// no dependencies
package mrp_pkg;

    localparam logic [7:0]  FUNC_READ  = 8'h03;
    localparam logic [7:0]  COUNT_TWO  = 8'h02;
    localparam logic [7:0]  ADDR_RESET = 8'h01;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    // reciprocal of ten, scaled by 2^19, exact for every 16-bit value
    localparam logic [15:0] RECIP_TEN  = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    localparam int FIFO_DEPTH_DEFAULT = 2;

    typedef enum logic [2:0] {
        ST_ADDR    = 3'd0,
        ST_FUNC    = 3'd1,
        ST_COUNT   = 3'd2,
        ST_DATA_HI = 3'd3,
        ST_DATA_LO = 3'd4,
        ST_CRC_LO  = 3'd5,
        ST_CRC_HI  = 3'd6
    } frame_stage_t;

    // one completed frame passed from parser to arithmetic side
    typedef struct packed {
        logic        ok;
        logic [15:0] value;
    } frame_rec_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/mrp_front.sv =====
// byte-level frame recogniser with running crc-16
// depends on mrp_pkg
module mrp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              push_valid,
    input  logic              push_ready,
    output mrp_pkg::frame_rec_t push_rec
);
    import mrp_pkg::*;

    frame_stage_t stage_reg, stage_next;
    logic [7:0]   device_address_reg;
    logic [15:0]  crc_reg, crc_next;
    logic [15:0]  value_reg, value_next;
    logic [7:0]   crc_low_reg, crc_low_next;
    logic         accept;
    logic [15:0]  crc_upd;

    // only the final byte needs room in the queue
    assign in_ready = (stage_reg != ST_CRC_HI) || push_ready;
    assign accept   = in_valid && in_ready;
    assign crc_upd  = crc_byte((stage_reg == ST_ADDR) ? CRC_INIT : crc_reg, rx_byte);

    always_comb
    begin
        stage_next = stage_reg;
        if (accept)
        begin
            unique case (stage_reg)
                ST_ADDR:    stage_next = (rx_byte == device_address_reg) ? ST_FUNC : ST_ADDR;
                ST_FUNC:    stage_next = (rx_byte == FUNC_READ) ? ST_COUNT : ST_ADDR;
                ST_COUNT:   stage_next = (rx_byte == COUNT_TWO) ? ST_DATA_HI : ST_ADDR;
                ST_DATA_HI: stage_next = ST_DATA_LO;
                ST_DATA_LO: stage_next = ST_CRC_LO;
                ST_CRC_LO:  stage_next = ST_CRC_HI;
                ST_CRC_HI:  stage_next = ST_ADDR;
                default:    stage_next = ST_ADDR;
            endcase
        end
    end

    always_comb
    begin
        crc_next       = crc_reg;
        value_next     = value_reg;
        crc_low_next   = crc_low_reg;
        push_valid     = 1'b0;
        push_rec.ok    = (crc_low_reg == crc_reg[7:0]) && (rx_byte == crc_reg[15:8]);
        push_rec.value = value_reg;
        if (accept)
        begin
            unique case (stage_reg)
                ST_ADDR:    if (rx_byte == device_address_reg) crc_next = crc_upd;
                ST_FUNC:    if (rx_byte == FUNC_READ) crc_next = crc_upd;
                ST_COUNT:   if (rx_byte == COUNT_TWO) crc_next = crc_upd;
                ST_DATA_HI:
                begin
                    crc_next   = crc_upd;
                    value_next = {rx_byte, 8'h00};
                end
                ST_DATA_LO:
                begin
                    crc_next   = crc_upd;
                    value_next = {value_reg[15:8], rx_byte};
                end
                ST_CRC_LO:  crc_low_next = rx_byte;
                ST_CRC_HI:  push_valid = 1'b1;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg          <= ST_ADDR;
            device_address_reg <= ADDR_RESET;
            crc_reg            <= CRC_INIT;
            value_reg          <= 16'h0000;
            crc_low_reg        <= 8'h00;
        end
        else
        begin
            stage_reg   <= stage_next;
            crc_reg     <= crc_next;
            value_reg   <= value_next;
            crc_low_reg <= crc_low_next;
            if (cfg_we)
                device_address_reg <= cfg_wdata;
        end
    end

endmodule

// ===== hw/rtl/mrp_fifo.sv =====
// small register queue of completed frames between parser and arithmetic side
// depends on mrp_pkg
module mrp_fifo #(
    parameter int DEPTH = mrp_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  mrp_pkg::frame_rec_t push_rec,
    output logic                pop_valid,
    input  logic                pop_ready,
    output mrp_pkg::frame_rec_t pop_rec
);
    import mrp_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    frame_rec_t      mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;
    logic            do_push, do_pop;

    assign push_ready = (cnt_reg != FullCnt);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_rec    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== hw/rtl/mrp_back.sv =====
// divide-by-ten split of the data word and the result register
// depends on mrp_pkg
module mrp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  mrp_pkg::frame_rec_t pop_rec,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                frame_ok,
    output logic [15:0]         raw_value,
    output logic [12:0]         whole_part,
    output logic [3:0]          tenth_part
);
    import mrp_pkg::*;

    logic        a_valid_reg;
    logic        a_ok_reg;
    logic [15:0] a_value_reg;
    logic [31:0] a_prod_reg;
    logic        out_valid_reg;
    logic        ok_reg;
    logic [15:0] value_reg;
    logic [12:0] whole_reg;
    logic [3:0]  tenth_reg;
    logic        adv_b, a_free;
    logic [12:0] quot;
    logic [15:0] rem_full;

    assign adv_b     = !out_valid_reg || out_ready;
    assign a_free    = !a_valid_reg || adv_b;
    assign pop_ready = a_free;

    // quotient from the scaled product, remainder by shift-and-add back-multiply
    assign quot     = a_prod_reg[RECIP_SHIFT +: 13];
    assign rem_full = a_value_reg - ({3'b000, quot} << 3) - ({3'b000, quot} << 1);

    always_ff @(posedge clk)
    begin
        if (a_free && pop_valid)
        begin
            a_ok_reg    <= pop_rec.ok;
            a_value_reg <= pop_rec.value;
            a_prod_reg  <= pop_rec.value * RECIP_TEN;
        end
        if (adv_b && a_valid_reg)
        begin
            ok_reg    <= a_ok_reg;
            value_reg <= a_value_reg;
            whole_reg <= quot;
            tenth_reg <= rem_full[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_valid_reg <= pop_valid;
            if (adv_b)
                out_valid_reg <= a_valid_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_ok   = ok_reg;
    assign raw_value  = value_reg;
    assign whole_part = whole_reg;
    assign tenth_part = tenth_reg;

endmodule

// ===== hw/rtl/modbus_reply_parser_crc16.sv =====
// top level of the modbus rtu read-reply parser with crc-16 check
// depends on mrp_pkg, mrp_front, mrp_fifo, mrp_back
//
// takes received serial bytes one per cycle on a valid/ready channel and
// recognises the seven-byte read reply: slave address (cfg register, reset 1),
// function 0x03, byte count 0x02, data high, data low, crc low, crc high.
// a wrong header byte drops back to waiting for an address without looking
// at that byte again. the modbus crc-16 (reflected poly 0xa001, seed 0xffff)
// covers the first five bytes and is folded in one byte per cycle. on the
// seventh byte one result is produced: frame_ok, the 16-bit data word and its
// split into value/10 and value%10; a bad crc still yields a result with
// frame_ok low. a byte is taken every cycle; the only stall on the input is
// the final crc byte while the frame queue (FIFO_DEPTH entries) is full.
// a result goes through the frame queue and then the divide-by-ten, which is
// one reciprocal multiply stage then one register. the address register is
// to be written with cfg_we/cfg_wdata only while idle, unchecked by the block.
module modbus_reply_parser_crc16 #(
    parameter int FIFO_DEPTH = mrp_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: expected slave address
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // received byte stream
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // decoded reply
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_ok,
    output logic [15:0] raw_value,
    output logic [12:0] whole_part,
    output logic [3:0]  tenth_part
);
    import mrp_pkg::*;

    logic       push_valid, push_ready;
    frame_rec_t push_rec;
    logic       pop_valid, pop_ready;
    frame_rec_t pop_rec;

    // front: header match, crc fold, data capture
    mrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    // completed frames waiting for the arithmetic side
    mrp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    // back: divide by ten and hold the result until taken
    mrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_ok   (frame_ok),
        .raw_value  (raw_value),
        .whole_part (whole_part),
        .tenth_part (tenth_part)
    );

endmodule
